// ===== hw/rtl/sha256_stream_hasher_defines.svh =====
// Assertion macros for the SHA-256 stream hasher.
// Used by sha256_stream_hasher.sv; no other dependencies.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: codes, states, constants, functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
  localparam logic [1:0] FUNC_ABSORB  = 2'd0;
  localparam logic [1:0] FUNC_FINISH  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_OUT, ST_ERR
  } state_t;

  typedef logic [31:0] word_t;

  function automatic word_t init_h(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: byte absorb, padding, round unit, digest output.
// Depends on sha_pkg and sha256_stream_hasher_defines.svh.
//
//  channel | ports                                    | direction
//  in      | in_valid in_ready in_func in_data_byte   | transactions into the block
//  out     | out_valid out_ready out_status           | results out of the block
//          | out_digest_word out_word_index out_last_word
//
// An absorb transaction stores one byte; when it completes a 64-byte block,
// the one round unit runs a load step, 64 rounds and an add-back step.
// A finish runs one or two compressions for the padding, then sends eight
// words, one per cycle that out_ready is high. Reset (rst_n low, synchronous)
// restores the initial hash. The block is not ready while it compresses or
// sends results; a stalled output simply holds the current word.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha_pkg::state_t state_r, state_nxt;

  sha_pkg::word_t hash_r [8];
  sha_pkg::word_t work_r [8];
  sha_pkg::word_t sched_r [16];
  // Message block stored as 16 big-endian words.
  sha_pkg::word_t blk_r [16];
  logic [5:0]  fill_r;
  logic [63:0] bitlen_r;
  logic        fin_r;
  logic [5:0]  rnd_r;
  logic [2:0]  widx_r;
  // Set while padding: the compression in progress belongs to a finish.
  logic        padding_r;
  // Set when a second (length-only) padded block is still to go.
  logic        pad2_r;

  logic in_fire, out_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (in_func == sha_pkg::FUNC_ABSORB) begin
            if (fin_r) state_nxt = sha_pkg::ST_ERR;
            else if (fill_r == 6'd63) state_nxt = sha_pkg::ST_LOAD;
          end else if (in_func == sha_pkg::FUNC_FINISH) begin
            state_nxt = fin_r ? sha_pkg::ST_OUT : sha_pkg::ST_PAD;
          end else begin
            state_nxt = state_r;
          end
        end
      end
      sha_pkg::ST_PAD:   state_nxt = sha_pkg::ST_LOAD;
      sha_pkg::ST_LOAD:  state_nxt = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (rnd_r == 6'd63) state_nxt = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (!padding_r) state_nxt = sha_pkg::ST_IDLE;
        else if (pad2_r) state_nxt = sha_pkg::ST_PAD;
        else state_nxt = sha_pkg::ST_OUT;
      end
      sha_pkg::ST_OUT: if (out_fire && widx_r == 3'd7) state_nxt = sha_pkg::ST_IDLE;
      sha_pkg::ST_ERR: if (out_fire) state_nxt = sha_pkg::ST_IDLE;
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready        = (state_r == sha_pkg::ST_IDLE);
    out_valid       = (state_r == sha_pkg::ST_OUT) || (state_r == sha_pkg::ST_ERR);
    out_status      = (state_r == sha_pkg::ST_ERR) ? sha_pkg::STATUS_ERR : sha_pkg::STATUS_OK;
    out_digest_word = (state_r == sha_pkg::ST_ERR) ? 32'd0 : hash_r[widx_r];
    out_word_index  = (state_r == sha_pkg::ST_ERR) ? 3'd0 : widx_r;
    out_last_word   = (state_r == sha_pkg::ST_ERR) || (widx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sha_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // Round unit inputs.
  sha_pkg::word_t w_cur, w2, w7, w15, w16, s0, s1, t1, t2, ee, aa;
  always_comb begin
    w2  = sched_r[4'(rnd_r - 6'd2)];
    w7  = sched_r[4'(rnd_r - 6'd7)];
    w15 = sched_r[4'(rnd_r - 6'd15)];
    w16 = sched_r[rnd_r[3:0]];
    s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    w_cur = (rnd_r < 6'd16) ? blk_r[rnd_r[3:0]] : (s1 + w7 + s0 + w16);
    ee = work_r[4];
    aa = work_r[0];
    t1 = work_r[7] + (sha_pkg::rotr(ee, 6) ^ sha_pkg::rotr(ee, 11) ^ sha_pkg::rotr(ee, 25))
       + ((ee & work_r[5]) ^ (~ee & work_r[6])) + sha_pkg::ROUND_K[rnd_r] + w_cur;
    t2 = (sha_pkg::rotr(aa, 2) ^ sha_pkg::rotr(aa, 13) ^ sha_pkg::rotr(aa, 22))
       + ((aa & work_r[1]) ^ (aa & work_r[2]) ^ (work_r[1] & work_r[2]));
  end

  logic [1:0] bsel;
  assign bsel = fill_r[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= sha_pkg::init_h(3'(i));
      fill_r    <= '0;
      bitlen_r  <= '0;
      fin_r     <= 1'b0;
      rnd_r     <= '0;
      widx_r    <= '0;
      padding_r <= 1'b0;
      pad2_r    <= 1'b0;
    end else begin
      unique case (state_r)
        sha_pkg::ST_IDLE: begin
          widx_r <= '0;
          if (in_fire && in_func == sha_pkg::FUNC_ABSORB && !fin_r) begin
            blk_r[fill_r[5:2]][8*(3-bsel) +: 8] <= in_data_byte;
            fill_r   <= fill_r + 6'd1;
            bitlen_r <= bitlen_r + 64'd8;
          end else if (in_fire && in_func == sha_pkg::FUNC_FINISH && !fin_r) begin
            // Place 0x80 and clear the rest of the current word and after.
            for (int j = 0; j < 16; j++) begin
              if (j > int'(fill_r[5:2])) blk_r[j] <= '0;
            end
            blk_r[fill_r[5:2]] <= (blk_r[fill_r[5:2]] & ~(32'hffffffff >> (8 * bsel)))
                                  | (32'h80000000 >> (8 * bsel));
            padding_r <= 1'b1;
            pad2_r    <= (fill_r >= 6'd56);
          end else if (in_fire && in_func == sha_pkg::FUNC_RESTART) begin
            for (int i = 0; i < 8; i++) hash_r[i] <= sha_pkg::init_h(3'(i));
            fill_r   <= '0;
            bitlen_r <= '0;
            fin_r    <= 1'b0;
          end
        end
        sha_pkg::ST_PAD: begin
          // Final pass writes the length; a two-block pad also zeros words 0-13.
          if (!pad2_r) begin
            blk_r[14] <= bitlen_r[63:32];
            blk_r[15] <= bitlen_r[31:0];
          end else if (fill_r == 6'd0) begin
            for (int j = 0; j < 14; j++) blk_r[j] <= '0;
            blk_r[14] <= bitlen_r[63:32];
            blk_r[15] <= bitlen_r[31:0];
            pad2_r <= 1'b0;
          end
        end
        sha_pkg::ST_LOAD: begin
          for (int i = 0; i < 8; i++) work_r[i] <= hash_r[i];
          rnd_r <= '0;
        end
        sha_pkg::ST_ROUND: begin
          sched_r[rnd_r[3:0]] <= w_cur;
          work_r[7] <= work_r[6];
          work_r[6] <= work_r[5];
          work_r[5] <= work_r[4];
          work_r[4] <= work_r[3] + t1;
          work_r[3] <= work_r[2];
          work_r[2] <= work_r[1];
          work_r[1] <= work_r[0];
          work_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
        end
        sha_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + work_r[i];
          fill_r <= '0;
          if (padding_r && !pad2_r) begin
            padding_r <= 1'b0;
            fin_r     <= 1'b1;
          end
        end
        sha_pkg::ST_OUT: if (out_fire) widx_r <= widx_r + 3'd1;
        sha_pkg::ST_ERR: ;
        default: ;
      endcase
    end
  end

  `SHA_ASSERT(a_busy_not_ready, clk, rst_n, (state_r == sha_pkg::ST_ROUND) |-> !in_ready, "ready during rounds")
  `SHA_ASSERT(a_out_only_idle, clk, rst_n, out_valid |-> !in_ready, "ready while output pending")
  `SHA_ASSERT(a_err_single, clk, rst_n, (out_fire && out_status) |-> out_last_word, "error not last")
  `SHA_ASSERT_NORST(a_reset_idle, clk, !rst_n |=> !out_valid, "output after reset")
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the SHA-256 stream hasher: directed table, then random messages.
// Depends on sha_pkg (function codes, status codes) and the sha256_stream_hasher RTL.
`timescale 1ns / 1ps
module testbench;

  // One expected digest result, as the block should present it on the out_ channel.
  typedef struct {
    logic        status;
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_result_t;

  // One row of the directed table. When has_known is set, the expected first
  // word is typed in and checked against the predictor as a sanity check too.
  typedef struct {
    logic [1:0]  func;
    logic [7:0]  data;
    bit          has_known;
    logic [31:0] known_word;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_status;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_word(out_last_word)
  );

  // Round constants used by the predictor, in the standard order.
  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Predictor state: a private copy of the chaining value, the partial block,
  // the running message length in bits and the finished marker.
  logic [31:0] chain [8];
  logic [7:0]  pend_block [64];
  int unsigned pend_fill;
  logic [63:0] msg_bits;
  bit          is_finished;

  digest_result_t pending_digests[$];
  int unsigned    fail_count;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression of pend_block into chain, with a rolling 16-word schedule.
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, x2, x15;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = {pend_block[4*r], pend_block[4*r+1], pend_block[4*r+2], pend_block[4*r+3]};
      end else begin
        x2  = w[(r - 2) & 15];
        x15 = w[(r - 15) & 15];
        wt = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[(r - 7) & 15]
           + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[r & 15];
      end
      w[r & 15] = wt;
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic hasher_clear();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    for (int i = 0; i < 64; i++) pend_block[i] = 8'h00;
    pend_fill = 0;
    msg_bits = '0;
    is_finished = 0;
  endtask

  // Advances the predictor by one accepted transaction and queues its results.
  task automatic predict_digest(input logic [1:0] func, input logic [7:0] data);
    digest_result_t r;
    int unsigned pos;
    case (func)
      sha_pkg::FUNC_ABSORB: begin
        if (is_finished) begin
          r.status = sha_pkg::STATUS_ERR; r.word = '0; r.index = '0; r.last = 1'b1;
          pending_digests.insert(pending_digests.size(), r);
        end else begin
          pend_block[pend_fill] = data;
          pend_fill++;
          if (pend_fill == 64) begin
            compress_block();
            pend_fill = 0;
          end
          msg_bits += 64'd8;
        end
      end
      sha_pkg::FUNC_FINISH: begin
        if (!is_finished) begin
          pos = pend_fill;
          pend_block[pos] = 8'h80;
          pos++;
          if (pos > 56) begin
            while (pos < 64) begin
              pend_block[pos] = 8'h00;
              pos++;
            end
            compress_block();
            pos = 0;
          end
          while (pos < 56) begin
            pend_block[pos] = 8'h00;
            pos++;
          end
          for (int i = 0; i < 8; i++) pend_block[56 + i] = msg_bits[63 - 8*i -: 8];
          compress_block();
          pend_fill = 0;
          is_finished = 1;
        end
        for (int i = 0; i < 8; i++) begin
          r.status = sha_pkg::STATUS_OK; r.word = chain[i]; r.index = i[2:0];
          r.last = (i == 7);
          pending_digests.insert(pending_digests.size(), r);
        end
      end
      sha_pkg::FUNC_RESTART: hasher_clear();
      default: ;
    endcase
  endtask

  // Often no idle gap at all, else mostly short ones, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Clock: 8 ns period.
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Sends one transaction: valid is raised and held with a stable payload
  // until the handshake completes. The predictor updates at acceptance.
  task automatic send_txn(input logic [1:0] func, input logic [7:0] data);
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digest(func, data);
  endtask

  // Drops valid for a random number of cycles between transactions, or not at all.
  task automatic sender_gap();
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_with_gap(input logic [1:0] func, input logic [7:0] data);
    sender_gap();
    send_txn(func, data);
  endtask

  // Holds the input side idle until every queued digest word has been
  // checked, then waits out any compression the block may still be running.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Result side: out_ready toggles at random with gaps of varying length.
  // Each accepted result is compared field by field against the oldest
  // expected digest word.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid) begin
        if (pending_digests.size() == 0) begin
          $error("result with nothing expected: word %h index %0d", out_digest_word,
                 out_word_index);
          fail_count++;
        end else begin
          digest_result_t e;
          e = pending_digests.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status);
            fail_count++;
          end
          if (out_digest_word !== e.word) begin
            $error("digest_word: expected %h actual %h", e.word, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== e.index) begin
            $error("word_index: expected %0d actual %0d", e.index, out_word_index);
            fail_count++;
          end
          if (out_last_word !== e.last) begin
            $error("last_word: expected %0d actual %0d", e.last, out_last_word);
            fail_count++;
          end
        end
      end
    end
  end

  // Directed table. Known first words: SHA-256 of the empty message and of
  // "abc". Rows without a known value rely on the predictor alone.
  stim_row_t directed [17] = '{
    '{sha_pkg::FUNC_FINISH,  8'h00, 1'b1, 32'he3b0c442},  // empty message
    '{sha_pkg::FUNC_FINISH,  8'hff, 1'b1, 32'he3b0c442},  // repeated finish re-sends
    '{sha_pkg::FUNC_ABSORB,  8'h00, 1'b0, 32'h0},         // absorb after finish is rejected
    '{FUNC_UNUSED,           8'h5a, 1'b0, 32'h0},         // unused code is ignored
    '{sha_pkg::FUNC_RESTART, 8'h00, 1'b0, 32'h0},
    '{sha_pkg::FUNC_ABSORB,  8'h61, 1'b0, 32'h0},
    '{sha_pkg::FUNC_ABSORB,  8'h62, 1'b0, 32'h0},
    '{sha_pkg::FUNC_ABSORB,  8'h63, 1'b0, 32'h0},
    '{sha_pkg::FUNC_FINISH,  8'h00, 1'b1, 32'hba7816bf},  // "abc"
    '{sha_pkg::FUNC_ABSORB,  8'hff, 1'b0, 32'h0},         // rejected again
    '{sha_pkg::FUNC_RESTART, 8'hff, 1'b0, 32'h0},
    '{sha_pkg::FUNC_ABSORB,  8'hff, 1'b0, 32'h0},
    '{sha_pkg::FUNC_ABSORB,  8'h00, 1'b0, 32'h0},
    '{FUNC_UNUSED,           8'h00, 1'b0, 32'h0},         // ignored mid-message
    '{sha_pkg::FUNC_ABSORB,  8'haa, 1'b0, 32'h0},
    '{sha_pkg::FUNC_FINISH,  8'h00, 1'b0, 32'h0},
    '{sha_pkg::FUNC_RESTART, 8'h00, 1'b0, 32'h0}
  };

  // Main stimulus: reset, directed table, then random messages whose lengths
  // straddle the padding boundaries (55, 56, 63 and 64 bytes).
  initial begin
    int unsigned sent, len, p;
    logic [1:0]  f;
    fail_count = 0;
    hasher_clear();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_func      <= sha_pkg::FUNC_ABSORB;
    in_data_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_with_gap(directed[i].func, directed[i].data);
      if (directed[i].has_known && chain[0] !== directed[i].known_word) begin
        $error("digest_word: expected %h actual %h", directed[i].known_word, chain[0]);
        fail_count++;
      end
    end

    // Sender holds off until every outstanding digest word is out.
    drain_results();

    // Boundary-length messages, each a complete absorb-then-finish run.
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: len = 55;
        1: len = 56;
        2: len = 63;
        default: len = 64;
      endcase
      send_with_gap(sha_pkg::FUNC_RESTART, 8'($urandom));
      for (int b = 0; b < len; b++) send_with_gap(sha_pkg::FUNC_ABSORB, 8'($urandom));
      send_with_gap(sha_pkg::FUNC_FINISH, 8'($urandom));
    end

    // Random part: mostly well-formed messages of random content with short
    // lengths, plus noise (stray finishes, rejected absorbs, unused codes).
    sent = 0;
    while (sent < 240) begin
      p = $urandom_range(99);
      len = (p < 85) ? $urandom_range(20) : $urandom_range(70, 21);
      send_with_gap(sha_pkg::FUNC_RESTART, 8'($urandom));
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(30) == 0) f = FUNC_UNUSED;
        else f = sha_pkg::FUNC_ABSORB;
        send_with_gap(f, 8'($urandom));
      end
      send_with_gap(sha_pkg::FUNC_FINISH, 8'($urandom));
      sent += len + 2;
      if ($urandom_range(3) == 0) begin
        send_with_gap(sha_pkg::FUNC_ABSORB, 8'($urandom));
        sent++;
      end
      if ($urandom_range(4) == 0) begin
        send_with_gap(sha_pkg::FUNC_FINISH, 8'($urandom));
        sent++;
      end
      if ($urandom_range(9) == 0) drain_results();
    end

    drain_results();
    if (fail_count == 0 && pending_digests.size() == 0) begin
      $display("testbench OK");
    end else begin
      if (pending_digests.size() != 0)
        $error("%0d expected results never arrived", pending_digests.size());
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule

// ===== sha256_stream_hasher.f =====
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha256_stream_hasher.sv
dv/testbench.sv
